// File: src/ggc_pkg.sv
`timescale 1ns / 1ps

package ggc_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 4096;
  localparam int unsigned DEF_MAX_COLORS   = 64;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned VERTEX_W   = 12;
  localparam int unsigned COLOR_W    = 6;
  localparam int unsigned CCOUNT_W   = 7;
  localparam int unsigned POSITION_W = 13;

  localparam logic [CCOUNT_W-1:0]   COLOR_COUNT_RESET = 7'd8;
  localparam logic [POSITION_W-1:0] POSITION_MAX      = 13'd8191;

  // width of the run tag kept next to each stored colour
  localparam int unsigned EPOCH_W = 8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NBR    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_NBR,
    KIND_FIN
  } ggc_kind_e;

  typedef struct packed {
    ggc_kind_e             kind;
    logic [VERTEX_W-1:0]   vertex;
    logic [VERTEX_W-1:0]   neighbor;
    logic                  in_range;  // finish vertex lies inside the store
  } ggc_item_t;

endpackage

// File: src/ggc_front.sv
`timescale 1ns / 1ps

module ggc_front import ggc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic [VERTEX_W-1:0] neighbor_i,
  input  logic                sweep_i,
  input  logic                q_full_i,
  output logic                busy_o,
  output logic                push_o,
  output ggc_item_t           item_o
);

  logic      valid_q, valid_d;
  ggc_item_t item_q, item_d;
  logic      keep;
  logic      accept;

  assign busy_o = sweep_i || (valid_q && q_full_i);
  assign accept = start_i && !busy_o;
  assign push_o = valid_q && !q_full_i;
  assign item_o = item_q;

  // classify: unused codes and neighbours outside the store are dropped here
  always_comb begin
    keep             = 1'b0;
    item_d.kind      = KIND_CLEAR;
    item_d.vertex    = vertex_i;
    item_d.neighbor  = neighbor_i;
    item_d.in_range  = (32'(vertex_i) < 32'(MAX_VERTICES));
    case (func_i)
      FUNC_CLEAR: begin
        keep        = 1'b1;
        item_d.kind = KIND_CLEAR;
      end
      FUNC_NBR: begin
        keep        = (32'(neighbor_i) < 32'(MAX_VERTICES));
        item_d.kind = KIND_NBR;
      end
      FUNC_FINISH: begin
        keep        = 1'b1;
        item_d.kind = KIND_FIN;
      end
      default: keep = 1'b0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = keep;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        item_q <= item_d;
      end
    end
  end

endmodule

// File: src/ggc_queue.sv
`timescale 1ns / 1ps

module ggc_queue import ggc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ggc_item_t item_i,
  input  logic      pop_i,
  output ggc_item_t item_o,
  output logic      full_o,
  output logic      empty_o
);

  ggc_item_t             store_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     cnt_q;

  assign full_o  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/ggc_back.sv
`timescale 1ns / 1ps

module ggc_back import ggc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_COLORS   = DEF_MAX_COLORS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CCOUNT_W-1:0] cfg_data_i,
  input  logic                q_empty_i,
  input  ggc_item_t           q_item_i,
  output logic                q_pop_o,
  output logic                sweep_o,
  output logic                done_o,
  output logic [VERTEX_W-1:0] colored_vertex_o,
  output logic [COLOR_W-1:0]  color_o,
  output logic                overflow_o
);

  localparam int unsigned AW     = $clog2(MAX_VERTICES);
  localparam int unsigned NG     = (MAX_COLORS + 7) / 8;
  localparam int unsigned MASK_W = NG * 8;
  localparam int unsigned CW     = $clog2(MASK_W);
  localparam int unsigned GW     = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned DCW    = $clog2(POSITION_W);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_NB,
    ST_FIN1,
    ST_FIN2,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [COLOR_W-1:0] color;
  } ggc_entry_t;

  // colour store, tagged with the run it was written in
  ggc_entry_t mem [MAX_VERTICES];
  ggc_entry_t rd_q;
  logic       mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  ggc_entry_t mem_wdata;

  state_e                state_q;
  logic [CCOUNT_W-1:0]   cc_q;
  logic [CCOUNT_W-1:0]   n_eff, n_m1;
  logic [MASK_W-1:0]     mask_q;
  logic [POSITION_W-1:0] pos_q;
  logic [COLOR_W-1:0]    rem_q;
  logic                  par_q;
  logic [EPOCH_W-1:0]    epoch_q;
  logic [AW-1:0]         sweep_addr_q;
  logic [VERTEX_W-1:0]   fin_vtx_q;
  logic                  fin_in_q;
  logic [NG-1:0]         grp_any_q, grp_any_d;
  logic [2:0]            grp_idx_q [NG];
  logic [2:0]            grp_idx_d [NG];
  logic                  div_pend_q;
  logic [DCW-1:0]        div_cnt_q;
  logic [COLOR_W-1:0]    div_r_q;
  logic [CCOUNT_W-1:0]   div_sh;
  logic                  div_ge;
  logic [COLOR_W-1:0]    div_nx;
  logic [CCOUNT_W-1:0]   rem_inc;
  logic [MASK_W-1:0]     avail;
  logic [GW-1:0]         gsel;
  logic                  found;
  logic [COLOR_W-1:0]    fin_color;
  logic                  fin_ovf;
  logic                  done_q;
  logic [VERTEX_W-1:0]   vtx_out_q;
  logic [COLOR_W-1:0]    color_q;
  logic                  ovf_q;
  logic                  take;

  assign sweep_o          = (state_q == ST_SWEEP);
  assign done_o           = done_q;
  assign colored_vertex_o = vtx_out_q;
  assign color_o          = color_q;
  assign overflow_o       = ovf_q;

  // palette size clamped to the legal range
  always_comb begin
    n_eff = cc_q;
    if (cc_q < CCOUNT_W'(2)) begin
      n_eff = CCOUNT_W'(2);
    end else if (cc_q > CCOUNT_W'(MAX_COLORS)) begin
      n_eff = CCOUNT_W'(MAX_COLORS);
    end
  end
  assign n_m1 = n_eff - 1'b1;

  assign take    = (state_q == ST_IDLE) && !div_pend_q && !q_empty_i;
  assign q_pop_o = take;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr_q;
    mem_wdata = '0;
    if (state_q == ST_SWEEP) begin
      mem_we = 1'b1;
    end else if (state_q == ST_FIN2) begin
      mem_we          = fin_in_q;
      mem_waddr       = AW'(fin_vtx_q);
      mem_wdata.epoch = epoch_q;
      mem_wdata.color = fin_color;
    end
    mem_re    = take && (q_item_i.kind == KIND_NBR);
    mem_raddr = AW'(q_item_i.neighbor);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // free regular colours
  always_comb begin
    for (int c = 0; c < MASK_W; c++) begin
      avail[c] = !mask_q[c] && (CCOUNT_W'(c) < n_m1);
    end
  end

  // first search level: best candidate inside each group of eight
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = |avail[g*8 +: 8];
      grp_idx_d[g] = 3'd0;
      if (par_q) begin
        for (int i = 0; i < 8; i++) begin
          if (avail[g*8 + i]) begin
            grp_idx_d[g] = 3'(i);
          end
        end
      end else begin
        for (int i = 7; i >= 0; i--) begin
          if (avail[g*8 + i]) begin
            grp_idx_d[g] = 3'(i);
          end
        end
      end
    end
  end

  // second level: pick the group, then the final colour
  always_comb begin
    gsel  = '0;
    found = |grp_any_q;
    if (par_q) begin
      for (int g = 0; g < NG; g++) begin
        if (grp_any_q[g]) begin
          gsel = GW'(g);
        end
      end
    end else begin
      for (int g = NG - 1; g >= 0; g--) begin
        if (grp_any_q[g]) begin
          gsel = GW'(g);
        end
      end
    end
    if (pos_q == '0) begin
      fin_color = '0;
      fin_ovf   = 1'b0;
    end else if (found) begin
      fin_color = COLOR_W'({gsel, grp_idx_q[gsel]});
      fin_ovf   = 1'b0;
    end else begin
      fin_color = COLOR_W'(n_m1);
      fin_ovf   = 1'b1;
    end
  end

  // restoring division step: position mod palette size and quotient parity
  assign div_sh  = {div_r_q, pos_q[div_cnt_q]};
  assign div_ge  = (div_sh >= n_eff);
  assign div_nx  = div_ge ? COLOR_W'(div_sh - n_eff) : COLOR_W'(div_sh);
  assign rem_inc = CCOUNT_W'(rem_q) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      cc_q         <= COLOR_COUNT_RESET;
      mask_q       <= '0;
      pos_q        <= '0;
      rem_q        <= '0;
      par_q        <= 1'b0;
      epoch_q      <= EPOCH_W'(1);
      sweep_addr_q <= '0;
      fin_vtx_q    <= '0;
      fin_in_q     <= 1'b0;
      grp_any_q    <= '0;
      for (int g = 0; g < NG; g++) begin
        grp_idx_q[g] <= '0;
      end
      div_pend_q   <= 1'b0;
      div_cnt_q    <= '0;
      div_r_q      <= '0;
      done_q       <= 1'b0;
      vtx_out_q    <= '0;
      color_q      <= '0;
      ovf_q        <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_SWEEP: begin
          if (sweep_addr_q == AW'(MAX_VERTICES - 1)) begin
            sweep_addr_q <= '0;
            state_q      <= ST_IDLE;
          end else begin
            sweep_addr_q <= sweep_addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (div_pend_q) begin
            div_pend_q <= 1'b0;
            div_cnt_q  <= DCW'(POSITION_W - 1);
            div_r_q    <= '0;
            state_q    <= ST_DIV;
          end else if (!q_empty_i) begin
            case (q_item_i.kind)
              KIND_CLEAR: begin
                mask_q <= '0;
                pos_q  <= '0;
                rem_q  <= '0;
                par_q  <= 1'b0;
                // tags exhausted: wipe the store and restart the tag count
                if (epoch_q == '1) begin
                  epoch_q      <= EPOCH_W'(1);
                  sweep_addr_q <= '0;
                  state_q      <= ST_SWEEP;
                end else begin
                  epoch_q <= epoch_q + 1'b1;
                end
              end
              KIND_NBR: begin
                state_q <= ST_NB;
              end
              KIND_FIN: begin
                fin_vtx_q <= q_item_i.vertex;
                fin_in_q  <= q_item_i.in_range;
                state_q   <= ST_FIN1;
              end
              default: ;
            endcase
          end
        end
        ST_NB: begin
          if (rd_q.epoch == epoch_q) begin
            mask_q[CW'(rd_q.color)] <= 1'b1;
          end
          state_q <= ST_IDLE;
        end
        ST_FIN1: begin
          grp_any_q <= grp_any_d;
          for (int g = 0; g < NG; g++) begin
            grp_idx_q[g] <= grp_idx_d[g];
          end
          state_q <= ST_FIN2;
        end
        ST_FIN2: begin
          done_q    <= 1'b1;
          vtx_out_q <= fin_vtx_q;
          color_q   <= fin_color;
          ovf_q     <= fin_ovf;
          mask_q    <= '0;
          if (pos_q != POSITION_MAX) begin
            pos_q <= pos_q + 1'b1;
            if (rem_inc == n_eff) begin
              rem_q <= '0;
              par_q <= !par_q;
            end else begin
              rem_q <= COLOR_W'(rem_inc);
            end
          end
          state_q <= ST_IDLE;
        end
        ST_DIV: begin
          div_r_q <= div_nx;
          if (div_cnt_q == '0) begin
            rem_q   <= div_nx;
            par_q   <= div_ge;
            state_q <= ST_IDLE;
          end else begin
            div_cnt_q <= div_cnt_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_we_i) begin
        cc_q       <= cfg_data_i;
        div_pend_q <= 1'b1;
      end
    end
  end

endmodule

// File: src/greedy_graph_coloring_core.sv
`timescale 1ns / 1ps
// A finish item passes front register, queue, ST_IDLE, ST_FIN1, ST_FIN2, then strobes done_o.
// Execution side: clear in ST_IDLE, neighbour via ST_NB (store read), finish via ST_FIN1/2.
// A color_count write holds the execution side off for a 13-step remainder pass.
// Reset: busy_o is high while every entry of the colour store is tagged clean;
// the same wipe recurs on every 255th clear. done_o cannot be stalled by the receiver.
module greedy_graph_coloring_core import ggc_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_COLORS   = DEF_MAX_COLORS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [VERTEX_W-1:0] vertex_i,
  input  logic [VERTEX_W-1:0] neighbor_i,
  input  logic                cfg_we_i,
  input  logic [CCOUNT_W-1:0] cfg_data_i,
  output logic                done_o,
  output logic [VERTEX_W-1:0] colored_vertex_o,
  output logic [COLOR_W-1:0]  color_o,
  output logic                overflow_o
);

  logic      push, pop, q_full, q_empty, sweep;
  ggc_item_t push_item, pop_item;

  ggc_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .func_i     (func_i),
    .vertex_i   (vertex_i),
    .neighbor_i (neighbor_i),
    .sweep_i    (sweep),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .item_o     (push_item)
  );

  ggc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (pop_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ggc_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_COLORS   (MAX_COLORS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .q_empty_i        (q_empty),
    .q_item_i         (pop_item),
    .q_pop_o          (pop),
    .sweep_o          (sweep),
    .done_o           (done_o),
    .colored_vertex_o (colored_vertex_o),
    .color_o          (color_o),
    .overflow_o       (overflow_o)
  );

endmodule
